[hw/rtl/utn_pkg.sv]
// ----------------------------------------------------------------------------
// utn_pkg: shared types, constants and byte classifiers
// Holds the queue entry format between the front and back parts, the result
// slot positions and the character class functions used by the front part.
// ----------------------------------------------------------------------------
package utn_pkg;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Result slot positions inside an entry's slot mask, in emission order.
    localparam int SLOT_SPACE = 0;
    localparam int SLOT_FIRST = 1;
    localparam int SLOT_SECOND = 2;
    localparam int SLOT_TERM = 3;
    localparam int NUM_SLOTS = 4;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic [7:0] UPPER_LO = 8'h41;
    localparam logic [7:0] UPPER_HI = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] LOWER_LO = 8'h61;
    localparam logic [7:0] LOWER_HI = 8'h7A;
    localparam logic [7:0] DIGIT_LO = 8'h30;
    localparam logic [7:0] DIGIT_HI = 8'h39;

    localparam logic [7:0] PUNCT_A_LO = 8'h21;
    localparam logic [7:0] PUNCT_A_HI = 8'h2F;
    localparam logic [7:0] PUNCT_B_LO = 8'h3A;
    localparam logic [7:0] PUNCT_B_HI = 8'h40;
    localparam logic [7:0] PUNCT_C_LO = 8'h5B;
    localparam logic [7:0] PUNCT_C_HI = 8'h60;

    localparam logic [15:0] CYR_LO = 16'hD090;
    localparam logic [15:0] CYR_HI = 16'hD18F;
    localparam logic [15:0] CYR_IO_UP = 16'hD081;
    localparam logic [15:0] CYR_IO_LO = 16'hD191;

    // One queue entry describes every result that one input transfer causes.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic [7:0]           first_byte;
        logic [7:0]           second_byte;
    } entry_t;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= UPPER_LO && b <= UPPER_HI)
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b >= PUNCT_A_LO && b <= PUNCT_A_HI) ||
               (b >= PUNCT_B_LO && b <= PUNCT_B_HI) ||
               (b >= PUNCT_C_LO && b <= PUNCT_C_HI);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= LOWER_LO && b <= LOWER_HI) || (b >= DIGIT_LO && b <= DIGIT_HI);
    endfunction

    function automatic logic is_cyrillic(input logic [15:0] pair);
        return (pair >= CYR_LO && pair <= CYR_HI) || pair == CYR_IO_UP ||
               pair == CYR_IO_LO;
    endfunction

endpackage

[hw/rtl/utn_front.sv]
// ----------------------------------------------------------------------------
// utn_front: byte classifier and text state
// Classifies each accepted byte, tracks the held lead byte and the space and
// start flags, and builds one queue entry listing the results it causes.
// ----------------------------------------------------------------------------
module utn_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              text_end,
    output logic              push,
    output utn_pkg::entry_t   entry
);

    logic [7:0] held_lead_reg, held_lead_next;
    logic       lead_pending_reg, lead_pending_next;
    logic       text_started_reg, text_started_next;
    logic       space_pending_reg, space_pending_next;

    logic [7:0]  low_byte;
    logic [15:0] pair;
    logic        space_mid;

    always_comb
    begin
        low_byte = utn_pkg::to_lower(in_byte);
        pair = {held_lead_reg, low_byte};

        held_lead_next = held_lead_reg;
        lead_pending_next = 1'b0;
        text_started_next = text_started_reg;
        space_pending_next = space_pending_reg;
        entry = '0;
        space_mid = space_pending_reg;

        if (lead_pending_reg && utn_pkg::is_cyrillic(pair))
        begin
            // Both bytes of a Cyrillic letter go out, after any pending space.
            entry.slots[utn_pkg::SLOT_SPACE] = space_pending_reg;
            entry.slots[utn_pkg::SLOT_FIRST] = 1'b1;
            entry.slots[utn_pkg::SLOT_SECOND] = 1'b1;
            entry.first_byte = held_lead_reg;
            entry.second_byte = low_byte;
            text_started_next = 1'b1;
            space_pending_next = 1'b0;
        end
        else
        begin
            // An unmatched lead byte counts as a space once text has started.
            if (lead_pending_reg)
            begin
                space_mid = space_pending_reg | text_started_reg;
            end
            space_pending_next = space_mid;
            if (utn_pkg::is_punct(low_byte))
            begin
                space_pending_next = space_mid | text_started_reg;
            end
            else if (utn_pkg::is_alnum(low_byte))
            begin
                entry.slots[utn_pkg::SLOT_SPACE] = space_mid;
                entry.slots[utn_pkg::SLOT_FIRST] = 1'b1;
                entry.first_byte = low_byte;
                text_started_next = 1'b1;
                space_pending_next = 1'b0;
            end
            else
            begin
                held_lead_next = low_byte;
                lead_pending_next = 1'b1;
            end
        end

        if (text_end)
        begin
            // The terminator closes the text; a held lead or trailing space is dropped.
            entry.slots[utn_pkg::SLOT_TERM] = 1'b1;
            held_lead_next = '0;
            lead_pending_next = 1'b0;
            text_started_next = 1'b0;
            space_pending_next = 1'b0;
        end

        push = accept && (entry.slots != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg <= '0;
            lead_pending_reg <= 1'b0;
            text_started_reg <= 1'b0;
            space_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_lead_reg <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            text_started_reg <= text_started_next;
            space_pending_reg <= space_pending_next;
        end
    end

    // A space can only be waiting once some byte of the text has gone out.
    assert property (@(posedge clk) disable iff (!rst_n)
        space_pending_reg |-> text_started_reg)
        else $error("space pending before text started");

endmodule

[hw/rtl/utn_queue.sv]
// ----------------------------------------------------------------------------
// utn_queue: entry queue between front and back
// A small register queue that decouples classification from result output.
// ----------------------------------------------------------------------------
module utn_queue
#(
    parameter int DEPTH = utn_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  utn_pkg::entry_t   push_entry,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output utn_pkg::entry_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    utn_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // The front never writes into a full queue, and the back never reads an empty one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push |-> !full) and (pop |-> head_valid))
        else $error("queue overflow or underflow");

endmodule

[hw/rtl/utn_back.sv]
// ----------------------------------------------------------------------------
// utn_back: result sequencer and output register
// Walks the result slots of the head entry, one result per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module utn_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  utn_pkg::entry_t   head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              text_done,
    output logic              run_last
);

    logic [utn_pkg::NUM_SLOTS-1:0] sent_reg, sent_next;
    logic [utn_pkg::NUM_SLOTS-1:0] pending;
    logic [utn_pkg::NUM_SLOTS-1:0] pick;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic       text_done_reg, text_done_next;
    logic       run_last_reg, run_last_next;

    logic load;
    logic last;

    always_comb
    begin
        pending = head.slots & ~sent_reg;
        pick = '0;
        out_byte_next = '0;
        byte_valid_next = 1'b1;
        text_done_next = 1'b0;
        priority if (pending[utn_pkg::SLOT_SPACE])
        begin
            pick[utn_pkg::SLOT_SPACE] = 1'b1;
            out_byte_next = utn_pkg::SPACE_CHAR;
        end
        else if (pending[utn_pkg::SLOT_FIRST])
        begin
            pick[utn_pkg::SLOT_FIRST] = 1'b1;
            out_byte_next = head.first_byte;
        end
        else if (pending[utn_pkg::SLOT_SECOND])
        begin
            pick[utn_pkg::SLOT_SECOND] = 1'b1;
            out_byte_next = head.second_byte;
        end
        else
        begin
            pick[utn_pkg::SLOT_TERM] = 1'b1;
            byte_valid_next = 1'b0;
            text_done_next = 1'b1;
        end

        last = ((pending & ~pick) == '0);
        run_last_next = last;
        load = head_valid && (!out_valid_reg || !out_stall);
        pop = load && last;

        sent_next = sent_reg;
        if (load)
        begin
            sent_next = last ? '0 : (sent_reg | pick);
        end

        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            text_done_reg <= text_done_next;
            run_last_reg <= run_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign text_done = text_done_reg;
    assign run_last = run_last_reg;

    // Partly sent slots only exist while their entry is still at the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sent_reg != '0) |-> head_valid)
        else $error("slot progress without a head entry");

    // A terminator is always the last result of its transfer and carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && text_done_reg) |-> (run_last_reg && !byte_valid_reg))
        else $error("terminator not last or carries a byte");

endmodule

[hw/rtl/utf8_text_normalizer.sv]
// ----------------------------------------------------------------------------
// utf8_text_normalizer: streaming UTF-8 text normalizer
// Lowercases ASCII, turns punctuation into single spaces, keeps two-byte
// Cyrillic letters, trims spaces and closes each text with a terminator.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_byte, text_end) takes one
// byte of text per transfer; text_end marks the last byte of a text. The
// output channel (out_valid, out_stall, out_byte, byte_valid, text_done,
// run_last) gives zero to four results per input transfer: a pending space,
// one or two text bytes, and the terminator (byte_valid low, text_done high).
// run_last flags the final result caused by an input transfer.
// The first result of an input transfer passes through the entry queue and
// then the output register. Throughput: one input transfer per cycle while
// each causes at most one result and out_stall is low; the output register
// sends one result per cycle while out_stall is low, and the entry queue of
// QUEUE_DEPTH items absorbs items with more than one result before in_stall
// rises. in_stall is high exactly when the queue is full.
// Reset clears the text state, the queue and the output register; no clearing
// pass is needed. While out_stall is high the output holds its result and
// the queue keeps filling until it is full.
// ----------------------------------------------------------------------------
module utf8_text_normalizer
#(
    parameter int QUEUE_DEPTH = utn_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       text_done,
    output logic       run_last
);

    // Front-to-queue and queue-to-back connections.
    logic            accept;
    logic            push;
    utn_pkg::entry_t push_entry;
    logic            queue_full;
    logic            head_valid;
    utn_pkg::entry_t head;
    logic            pop;

    // The input stalls only on a full queue, never on the output side directly.
    assign in_stall = queue_full;
    assign accept = in_valid && !queue_full;

    // Front part: classifies the byte and updates the text state on every transfer.
    utn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .text_end (text_end),
        .push     (push),
        .entry    (push_entry)
    );

    // Queue: transfers that cause no result are never written here.
    utn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back part: expands the head entry into results, one per cycle while the output is not stalled.
    utn_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .text_done  (text_done),
        .run_last   (run_last)
    );

endmodule
